FILE: sv/bcd_pkg.sv
// shared types, widths and register codes for the box containment distance core
package bcd_pkg;

    // number of spatial axes handled per word
    localparam int NAXES       = 3;
    // field widths
    localparam int COORD_W     = 24;
    localparam int HW_W        = 23;
    localparam int DIST_W      = 24;
    localparam int HWA_W       = 26;
    localparam int LIM_W       = HWA_W + 1;
    localparam int OVER_W      = 25;
    localparam int SQO_W       = 2 * OVER_W;
    localparam int SQC_W       = 2 * DIST_W;
    localparam int SUM_W       = SQO_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int OUT_W       = 25;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int MARGIN_W    = 24;

    // stream word widths
    localparam int S_FIELDS_W  = 6 * COORD_W + NAXES * HW_W + COORD_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * OUT_W + 7) / 8) * 8;

    // pipeline layout: two geometry stages, multiply, sum, one stage per root bit
    localparam int SQRT_STAGES = ROOT_W;
    localparam int ST_SQRT0    = 4;
    localparam int PIPE_STAGES = ST_SQRT0 + SQRT_STAGES;

    // saturation limit of the distance outputs
    localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_DIMS = 2'd0,
        CFG_OFFSET_MASK = 2'd1,
        CFG_COULOMB     = 2'd2,
        CFG_MARGIN      = 2'd3
    } cfg_idx_t;

    // decoded configuration seen by the geometry stages
    typedef struct packed {
        logic [NAXES-1:0]    active;
        logic [NAXES-1:0]    offset_en;
        logic                coulomb;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    // one unpacked input word
    typedef struct packed {
        logic [NAXES-1:0][COORD_W-1:0] point;
        logic [NAXES-1:0][COORD_W-1:0] center;
        logic [NAXES-1:0][HW_W-1:0]    half_width;
        logic [COORD_W-1:0]            adjust;
        logic                          measure;
    } item_t;

    // per-word flags that ride along the pipeline
    typedef struct packed {
        logic measure;
        logic near;
        logic in_box;
    } tag_t;

    // geometry result handed to the squaring stages
    typedef struct packed {
        tag_t                         tag;
        logic [NAXES-1:0][OVER_W-1:0] over;
        logic [NAXES-1:0][DIST_W-1:0] dcen;
    } geom_t;

    // squared sums handed to the root units
    typedef struct packed {
        tag_t             tag;
        logic [SUM_W-1:0] sum_surface;
        logic [SUM_W-1:0] sum_center;
    } sums_t;

endpackage

FILE: sv/box_containment_distance_core.sv
// top level: config registers, pipeline control, root units and output skid buffer
//
//  channel  | direction | word contents
//  ---------+-----------+-----------------------------------------------------------
//  s_       | in        | tdata: point x/y/z, center x/y/z, half width x/y/z, offset;
//           |           | tuser: measure_to_center
//  m_       | out       | tdata: dist_potential, dist_zone; tuser: in_wall, near_dielectric
//  cfg_     | in        | index 0 active_dims, 1 offset_enable_mask, 2 coulomb_mode,
//           |           | 3 dielectric_margin
//
// one word per cycle sustained while the skid buffer is empty; words pass the pipeline, then
// the output register; depth is set by the floor square root, which resolves one root bit per stage
// the output register is backed by a one-word skid buffer; the pipeline stalls as
// a whole only while the skid buffer is full, so s_tready is a register
// synchronous active-low reset clears valid bits and configuration only
module box_containment_distance_core
    import bcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x, point_y, point_z, wall_center_x, wall_center_y, wall_center_z,
    // half_width_x, half_width_y, half_width_z, offset_adjust, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // measure_to_center
    input  logic                 s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dist_potential, dist_zone, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // in_wall, near_dielectric
    output logic [1:0]           m_tuser,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef struct packed {
        logic [OUT_W-1:0] zone;
        logic [OUT_W-1:0] pot;
        logic             near;
        logic             in_box;
    } out_word_t;

    logic [1:0]             active_dims_reg;
    logic [NAXES-1:0]       offset_mask_reg;
    logic                   coulomb_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    cfg_t                   cfg;
    item_t                  item;
    logic                   adv;
    logic [PIPE_STAGES-1:0] valid_reg;
    geom_t                  geom;
    sums_t                  sums;
    tag_t                   tag_reg [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_zone;
    logic [ROOT_W-1:0]      root_cen;
    out_word_t              word_next;
    out_word_t              out_reg;
    out_word_t              skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_dims_reg <= 2'd3;
            offset_mask_reg <= '0;
            coulomb_reg     <= 1'b0;
            margin_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE_DIMS: active_dims_reg <= cfg_wdata[1:0];
                CFG_OFFSET_MASK: offset_mask_reg <= cfg_wdata[NAXES-1:0];
                CFG_COULOMB:     coulomb_reg     <= cfg_wdata[0];
                CFG_MARGIN:      margin_reg      <= cfg_wdata[MARGIN_W-1:0];
            endcase
        end
    end

    // axis enables from the active dimension count
    always_comb begin
        cfg.active[0] = (active_dims_reg >= 2'd1);
        cfg.active[1] = (active_dims_reg >= 2'd2);
        cfg.active[2] = (active_dims_reg == 2'd3);
        cfg.offset_en = offset_mask_reg;
        cfg.coulomb   = coulomb_reg;
        cfg.margin    = margin_reg;
    end

    // unpack the input word
    always_comb begin
        for (int d = 0; d < NAXES; d++) begin
            item.point[d]      = s_tdata[d*COORD_W +: COORD_W];
            item.center[d]     = s_tdata[(NAXES+d)*COORD_W +: COORD_W];
            item.half_width[d] = s_tdata[2*NAXES*COORD_W + d*HW_W +: HW_W];
        end
        item.adjust  = s_tdata[2*NAXES*COORD_W + NAXES*HW_W +: COORD_W];
        item.measure = s_tuser;
    end

    // pipeline moves whenever the skid buffer has room
    assign adv      = ~skid_valid_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_STAGES-2:0], s_tvalid};
        end
    end

    // datapath units
    bcd_geom u_geom (
        .aclk     (aclk),
        .adv      (adv),
        .in_item  (item),
        .cfg      (cfg),
        .geom_out (geom)
    );

    bcd_sqsum u_sqsum (
        .aclk     (aclk),
        .adv      (adv),
        .geom_in  (geom),
        .sums_out (sums)
    );

    bcd_isqrt u_sqrt_zone (
        .aclk     (aclk),
        .adv      (adv),
        .rad_in   (sums.sum_surface),
        .root_out (root_zone)
    );

    bcd_isqrt u_sqrt_cen (
        .aclk     (aclk),
        .adv      (adv),
        .rad_in   (sums.sum_center),
        .root_out (root_cen)
    );

    // flags follow the root stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= sums.tag;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // saturate, select the potential distance, force zero inside
    always_comb begin
        logic [OUT_W-1:0] zone_sat;
        logic [OUT_W-1:0] cen_sat;
        zone_sat = (root_zone > {1'b0, DIST_MAX}) ? DIST_MAX : root_zone[OUT_W-1:0];
        cen_sat  = (root_cen > {1'b0, DIST_MAX}) ? DIST_MAX : root_cen[OUT_W-1:0];
        word_next.in_box = tag_reg[SQRT_STAGES-1].in_box;
        word_next.near   = tag_reg[SQRT_STAGES-1].near;
        if (tag_reg[SQRT_STAGES-1].in_box) begin
            word_next.zone = '0;
            word_next.pot  = '0;
        end else begin
            word_next.zone = zone_sat;
            word_next.pot  = tag_reg[SQRT_STAGES-1].measure ? cen_sat : zone_sat;
        end
    end

    // output register with one-word skid buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= valid_reg[PIPE_STAGES-1];
        end else if (valid_reg[PIPE_STAGES-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_reg <= word_next;
        end else begin
            skid_reg <= word_next;
        end
    end

    // result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*OUT_W){1'b0}}, out_reg.zone, out_reg.pot};
    assign m_tuser  = {out_reg.near, out_reg.in_box};

`ifndef SYNTH
    // a point inside the box reports zero distances
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[2*OUT_W-1:0] == '0)
        else $error("inside word with nonzero distance");

    // skid buffer only fills behind a held output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer full with empty output register");

    // skid buffer fills only when a word leaves the pipeline into a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |->
            $past(out_valid_reg && !m_tready && valid_reg[PIPE_STAGES-1]))
        else $error("skid buffer filled without a stalled output");

    // a new result word only appears behind a valid last pipeline stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(valid_reg[PIPE_STAGES-1]))
        else $error("output valid without a word from the pipeline");
`endif

endmodule

FILE: sv/bcd_geom.sv
// geometry stages: per-axis center distance, adjusted half width, face tests
module bcd_geom
    import bcd_pkg::*;
(
    input  logic  aclk,
    input  logic  adv,
    input  item_t in_item,
    input  cfg_t  cfg,
    output geom_t geom_out
);

    logic [NAXES-1:0][DIST_W-1:0] dist_next;
    logic [NAXES-1:0][HWA_W-1:0]  hwa_next;
    logic [NAXES-1:0][DIST_W-1:0] dist_reg;
    logic [NAXES-1:0][HWA_W-1:0]  hwa_reg;
    logic                         measure_reg;
    logic [NAXES-1:0]             face;
    logic [NAXES-1:0]             near_fail;
    geom_t                        geom_next;
    geom_t                        geom_reg;

    // stage one: absolute center distance and adjusted half width per axis
    always_comb begin
        logic [COORD_W:0] diff;
        logic [COORD_W:0] mag;
        logic [HWA_W-1:0] adj_ext;
        for (int d = 0; d < NAXES; d++) begin
            diff = {in_item.center[d][COORD_W-1], in_item.center[d]}
                 - {in_item.point[d][COORD_W-1], in_item.point[d]};
            mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;
            dist_next[d] = mag[DIST_W-1:0];
            adj_ext = cfg.offset_en[d]
                    ? {{(HWA_W-COORD_W){in_item.adjust[COORD_W-1]}}, in_item.adjust}
                    : '0;
            hwa_next[d] = {{(HWA_W-HW_W){1'b0}}, in_item.half_width[d]} + adj_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg    <= dist_next;
            hwa_reg     <= hwa_next;
            measure_reg <= in_item.measure;
        end
    end

    // stage two: at-or-beyond-face tests, overshoot and dielectric margin test
    always_comb begin
        logic [HWA_W-1:0] dist_ext;
        logic [HWA_W-1:0] over_full;
        logic [LIM_W-1:0] lim;
        for (int d = 0; d < NAXES; d++) begin
            dist_ext     = {{(HWA_W-DIST_W){1'b0}}, dist_reg[d]};
            face[d]      = cfg.active[d] && ($signed(dist_ext) >= $signed(hwa_reg[d]));
            over_full    = dist_ext - hwa_reg[d];
            lim          = {hwa_reg[d][HWA_W-1], hwa_reg[d]}
                         + {{(LIM_W-MARGIN_W){1'b0}}, cfg.margin};
            near_fail[d] = cfg.active[d]
                         && ($signed({1'b0, dist_ext}) >= $signed(lim));
            geom_next.over[d] = face[d] ? over_full[OVER_W-1:0] : '0;
            geom_next.dcen[d] = face[d] ? dist_reg[d] : '0;
        end
        geom_next.tag.in_box  = ~|face;
        geom_next.tag.near    = cfg.coulomb & ~|near_fail;
        geom_next.tag.measure = measure_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            geom_reg <= geom_next;
        end
    end

    assign geom_out = geom_reg;

endmodule

FILE: sv/bcd_sqsum.sv
// squaring stage and sum stage for surface and center distances
module bcd_sqsum
    import bcd_pkg::*;
(
    input  logic  aclk,
    input  logic  adv,
    input  geom_t geom_in,
    output sums_t sums_out
);

    logic [NAXES-1:0][SQO_W-1:0] sq_over_reg;
    logic [NAXES-1:0][SQC_W-1:0] sq_cen_reg;
    tag_t                        tag_reg;
    sums_t                       sums_next;
    sums_t                       sums_reg;

    // one multiplier per axis and distance kind, registered
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int d = 0; d < NAXES; d++) begin
                sq_over_reg[d] <= SQO_W'(geom_in.over[d]) * SQO_W'(geom_in.over[d]);
                sq_cen_reg[d]  <= SQC_W'(geom_in.dcen[d]) * SQC_W'(geom_in.dcen[d]);
            end
            tag_reg <= geom_in.tag;
        end
    end

    // three-term sums
    always_comb begin
        sums_next.tag         = tag_reg;
        sums_next.sum_surface = {{(SUM_W-SQO_W){1'b0}}, sq_over_reg[0]}
                              + {{(SUM_W-SQO_W){1'b0}}, sq_over_reg[1]}
                              + {{(SUM_W-SQO_W){1'b0}}, sq_over_reg[2]};
        sums_next.sum_center  = {{(SUM_W-SQC_W){1'b0}}, sq_cen_reg[0]}
                              + {{(SUM_W-SQC_W){1'b0}}, sq_cen_reg[1]}
                              + {{(SUM_W-SQC_W){1'b0}}, sq_cen_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sums_reg <= sums_next;
        end
    end

    assign sums_out = sums_reg;

endmodule

FILE: sv/bcd_isqrt.sv
// pipelined floor square root, one root bit per stage
module bcd_isqrt
    import bcd_pkg::*;
(
    input  logic              aclk,
    input  logic              adv,
    input  logic [SUM_W-1:0]  rad_in,
    output logic [ROOT_W-1:0] root_out
);

    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES-1];
    logic [SUM_W-1:0]  rad_reg  [SQRT_STAGES-1];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [SUM_W-1:0]  rad_prev;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  rem_sub;
        logic              take;

        // previous partial state, zero remainder and root at the first stage
        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end

        // bring down two radicand bits and try root*4+1
        assign cur     = {rem_prev, rad_prev[SUM_W-1 -: 2]};
        assign trial   = {1'b0, root_prev, 2'b01};
        assign take    = (cur >= trial);
        assign rem_sub = cur - trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                root_reg[k] <= {root_prev[ROOT_W-2:0], take};
            end
        end

        if (k < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k] <= take ? rem_sub[REM_W-1:0] : cur[REM_W-1:0];
                    rad_reg[k] <= {rad_prev[SUM_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root_out = root_reg[SQRT_STAGES-1];

endmodule
